// ----- hw/rtl/rkb_pkg.sv -----
// Shared types, constants, sigmoid table and arithmetic helpers for the reward bias filters.
package rkb_pkg;

	localparam int SIGMOID_ENTRIES = 256;
	localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int SERIES_TERMS = 14;

	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam longint HALF_SPAN = 524288;
	localparam logic [16:0] BIAS_MAX = 17'd58982;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [63:0] SPAN = 64'sd34359738368;

	localparam logic [2:0] REG_NOISE_CUM = 3'd0;
	localparam logic [2:0] REG_NOISE_INC = 3'd1;
	localparam logic [2:0] REG_WEIGHT_CUM = 3'd2;
	localparam logic [2:0] REG_WEIGHT_INC = 3'd3;
	localparam logic [2:0] REG_POS_SIGMA = 3'd4;
	localparam logic [2:0] REG_NEG_SIGMA = 3'd5;

	localparam logic [63:0] EXP_INT_Q30 [9] = '{
		64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458457, 64'd19666267,
		64'd7234816, 64'd2661539, 64'd979126, 64'd360200
	};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RS_MP,
		ST_RS_MN,
		ST_RS_LD,
		ST_UPD_Z,
		ST_UPD_C0,
		ST_UPD_E,
		ST_DIV1_GO,
		ST_DIV1,
		ST_UPD_BB,
		ST_DIV2_GO,
		ST_DIV2,
		ST_BIAS_A,
		ST_BIAS_B,
		ST_BIAS_IDX,
		ST_BIAS_WR,
		ST_OUT
	} state_t;

	typedef logic [16:0] sig_tab_t [SIGMOID_ENTRIES];

	// shift-subtract quotient, used only while building the table
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] sum;
		logic [63:0] term;
		n = y >> 16;
		f = (y & 64'hFFFF) << 14;
		sum = ONE_Q30;
		term = ONE_Q30;
		if (n > 64'd8) n = 64'd8;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = udiv64((term * f) >> 30, 64'(k));
			if (k[0]) sum = sum - term;
			else sum = sum + term;
		end
		return (EXP_INT_Q30[n[3:0]] * sum) >> 30;
	endfunction

	function automatic logic [63:0] sigmoid_pos(logic [63:0] y);
		logic [63:0] d;
		d = ONE_Q30 + exp_neg_q30(y);
		return udiv64((64'd1 << 46) + (d >> 1), d);
	endfunction

	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		longint t;
		logic [63:0] v;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			t = ((2 * longint'(i) + 1) * HALF_SPAN) / SIGMOID_ENTRIES - HALF_SPAN;
			if (t >= 0) v = sigmoid_pos(64'(t));
			else v = 64'd65536 - sigmoid_pos(64'(-t));
			if (v > 64'(BIAS_MAX)) v = 64'(BIAS_MAX);
			tab[i] = v[16:0];
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] sx64(logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [IDX_W-1:0] sig_index(logic signed [63:0] s);
		logic [63:0] u;
		logic [63:0] p;
		u = 64'(s + SPAN);
		p = u * 64'(SIGMOID_ENTRIES);
		if (s < -SPAN) return '0;
		if (s >= SPAN) return IDX_W'(SIGMOID_ENTRIES - 1);
		return p[36 +: IDX_W];
	endfunction

endpackage

// ----- hw/rtl/reward_kalman_tree_bias.sv -----
// Top level: two Kalman reward filters sharing one multiplier and one divider.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   action, filter_select, reward_magnitude, motion_valid
//   out      from block out_valid/out_stall expand_goal_tree, chosen_bias, start_bias,
//                                           goal_bias, applied_increment
//   cfg      to block   cfg_we              cfg_index, cfg_data
//
// An update request runs two passes of the bit-serial divider (64 steps
// each); the divider is skipped when the increment variance is zero.
// One request is in flight at a time; the next is taken once the result
// sits in the output register. Reset is asynchronous and loads unit
// covariance and unit bias. A held output stalls the sequencer in its
// last step only.
module reward_kalman_tree_bias (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic        filter_select,
	input  logic [30:0] reward_magnitude,
	input  logic        motion_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        expand_goal_tree,
	output logic [16:0] chosen_bias,
	output logic [16:0] start_bias,
	output logic [16:0] goal_bias,
	output logic signed [31:0] applied_increment,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	rkb_pkg::state_t state_q, state_d;

	logic [16:0] noise_cum_q, noise_inc_q, weight_cum_q, weight_inc_q;
	logic [19:0] pos_sigma_q, neg_sigma_q;

	logic signed [31:0] pc_q [2];
	logic signed [31:0] pi_q [2];
	logic signed [31:0] cc_q [2];
	logic signed [31:0] ci_q [2];
	logic signed [31:0] ii_q [2];
	logic [16:0]        bias_q [2];
	logic signed [31:0] plim_q, nlim_q;

	logic        action_q, sel_q, valid_q, both_q;
	logic [30:0] mag_q;
	logic signed [31:0] z_q, x0_q;
	logic signed [63:0] prod_q, acc_q;
	logic [rkb_pkg::IDX_W-1:0] idx_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	logic               div_start, div_done;
	logic signed [63:0] div_num, div_quo;

	logic        accept, out_take, out_load;
	logic signed [31:0] a_c, b_c, c_c, pc_c, pi_c;
	logic signed [31:0] z_c, e_c, an_c;
	logic signed [32:0] mag_s;

	assign accept = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign out_load = (state_q == rkb_pkg::ST_OUT) && (!out_valid || !out_stall);

	assign a_c = cc_q[sel_q];
	assign b_c = ci_q[sel_q];
	assign c_c = ii_q[sel_q];
	assign pc_c = pc_q[sel_q];
	assign pi_c = pi_q[sel_q];
	assign mag_s = $signed({2'b00, mag_q});

	always_comb begin
		if (valid_q) begin
			z_c = (mag_s >= $signed({plim_q[31], plim_q})) ? plim_q : $signed({1'b0, mag_q});
		end else begin
			z_c = (mag_s >= $signed({nlim_q[31], nlim_q})) ? -nlim_q : 32'(-mag_s);
		end
	end

	assign e_c = rkb_pkg::sat32(rkb_pkg::sx64(z_q) - rkb_pkg::sx64(pi_c));
	assign an_c = rkb_pkg::sat32(rkb_pkg::sx64(a_c) - div_quo);
	assign mul_full = mul_a * mul_b;

	rkb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (c_c),
		.done   (div_done),
		.quo    (div_quo)
	);
	assign div_num = prod_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rkb_pkg::ST_IDLE:     if (accept) state_d = action ? rkb_pkg::ST_UPD_Z : rkb_pkg::ST_RS_MP;
			rkb_pkg::ST_RS_MP:    state_d = rkb_pkg::ST_RS_MN;
			rkb_pkg::ST_RS_MN:    state_d = rkb_pkg::ST_RS_LD;
			rkb_pkg::ST_RS_LD:    state_d = rkb_pkg::ST_BIAS_A;
			rkb_pkg::ST_UPD_Z:    state_d = (c_c == '0) ? rkb_pkg::ST_UPD_C0 : rkb_pkg::ST_UPD_E;
			rkb_pkg::ST_UPD_C0:   state_d = rkb_pkg::ST_BIAS_A;
			rkb_pkg::ST_UPD_E:    state_d = rkb_pkg::ST_DIV1_GO;
			rkb_pkg::ST_DIV1_GO:  state_d = rkb_pkg::ST_DIV1;
			rkb_pkg::ST_DIV1:     if (div_done) state_d = rkb_pkg::ST_UPD_BB;
			rkb_pkg::ST_UPD_BB:   state_d = rkb_pkg::ST_DIV2_GO;
			rkb_pkg::ST_DIV2_GO:  state_d = rkb_pkg::ST_DIV2;
			rkb_pkg::ST_DIV2:     if (div_done) state_d = rkb_pkg::ST_BIAS_A;
			rkb_pkg::ST_BIAS_A:   state_d = rkb_pkg::ST_BIAS_B;
			rkb_pkg::ST_BIAS_B:   state_d = rkb_pkg::ST_BIAS_IDX;
			rkb_pkg::ST_BIAS_IDX: state_d = rkb_pkg::ST_BIAS_WR;
			rkb_pkg::ST_BIAS_WR:  state_d = rkb_pkg::ST_OUT;
			rkb_pkg::ST_OUT:      if (out_load) state_d = rkb_pkg::ST_IDLE;
			default:              state_d = rkb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		in_stall = (state_q != rkb_pkg::ST_IDLE);
		unique case (state_q)
			rkb_pkg::ST_RS_MP: begin
				mul_a = $signed({13'b0, pos_sigma_q});
				mul_b = mag_s;
			end
			rkb_pkg::ST_RS_MN: begin
				mul_a = $signed({13'b0, neg_sigma_q});
				mul_b = mag_s;
			end
			rkb_pkg::ST_UPD_E: begin
				mul_a = $signed({b_c[31], b_c});
				mul_b = $signed({e_c[31], e_c});
			end
			rkb_pkg::ST_UPD_BB: begin
				mul_a = $signed({b_c[31], b_c});
				mul_b = $signed({b_c[31], b_c});
			end
			rkb_pkg::ST_BIAS_A: begin
				mul_a = $signed({16'b0, weight_cum_q});
				mul_b = $signed({pc_c[31], pc_c});
			end
			rkb_pkg::ST_BIAS_B: begin
				mul_a = $signed({16'b0, weight_inc_q});
				mul_b = $signed({pi_c[31], pi_c});
			end
			rkb_pkg::ST_DIV1_GO, rkb_pkg::ST_DIV2_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkb_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_cum_q <= 17'd66;
			noise_inc_q <= 17'd7;
			weight_cum_q <= 17'd45875;
			weight_inc_q <= 17'd19661;
			pos_sigma_q <= 20'd65536;
			neg_sigma_q <= 20'd131072;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rkb_pkg::REG_NOISE_CUM:  noise_cum_q <= cfg_data[16:0];
				rkb_pkg::REG_NOISE_INC:  noise_inc_q <= cfg_data[16:0];
				rkb_pkg::REG_WEIGHT_CUM: weight_cum_q <= cfg_data[16:0];
				rkb_pkg::REG_WEIGHT_INC: weight_inc_q <= cfg_data[16:0];
				rkb_pkg::REG_POS_SIGMA:  pos_sigma_q <= cfg_data;
				rkb_pkg::REG_NEG_SIGMA:  neg_sigma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < 2; f++) begin
				pc_q[f] <= '0;
				pi_q[f] <= '0;
				cc_q[f] <= 32'sd65536;
				ci_q[f] <= 32'sd65536;
				ii_q[f] <= 32'sd65536;
				bias_q[f] <= rkb_pkg::ONE_Q16;
			end
			plim_q <= '0;
			nlim_q <= '0;
		end else begin
			unique case (state_q)
				rkb_pkg::ST_RS_MN: plim_q <= rkb_pkg::sat32(prod_q >>> 16);
				rkb_pkg::ST_RS_LD: begin
					nlim_q <= rkb_pkg::sat32(prod_q >>> 16);
					for (int f = 0; f < 2; f++) begin
						pc_q[f] <= $signed({1'b0, mag_q});
						pi_q[f] <= '0;
						cc_q[f] <= $signed(32'd262144 + 32'(noise_cum_q));
						ci_q[f] <= 32'sd131072;
						ii_q[f] <= $signed(32'd65536 + 32'(noise_inc_q));
					end
				end
				rkb_pkg::ST_UPD_C0: begin
					pc_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(pc_c) + rkb_pkg::sx64(pi_c));
					pi_q[sel_q] <= pc_c;
					cc_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(a_c) + (rkb_pkg::sx64(b_c) <<< 1)
						+ rkb_pkg::sx64(c_c) + 64'(noise_cum_q));
					ci_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(a_c) + rkb_pkg::sx64(b_c));
					ii_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(a_c) + 64'(noise_inc_q));
				end
				rkb_pkg::ST_DIV2: if (div_done) begin
					pc_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(x0_q) + rkb_pkg::sx64(z_q));
					pi_q[sel_q] <= x0_q;
					cc_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(an_c) + 64'(noise_cum_q));
					ci_q[sel_q] <= an_c;
					ii_q[sel_q] <= rkb_pkg::sat32(rkb_pkg::sx64(an_c) + 64'(noise_inc_q));
				end
				rkb_pkg::ST_BIAS_WR: begin
					bias_q[sel_q] <= rkb_pkg::SIG_TABLE[idx_q];
					if (both_q) bias_q[1] <= rkb_pkg::SIG_TABLE[idx_q];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		if (accept) begin
			action_q <= action;
			sel_q <= action & filter_select;
			mag_q <= reward_magnitude;
			valid_q <= motion_valid;
			both_q <= !action;
		end
		if (state_q == rkb_pkg::ST_RS_LD) z_q <= $signed({1'b0, mag_q});
		if (state_q == rkb_pkg::ST_UPD_Z) z_q <= z_c;
		if (state_q == rkb_pkg::ST_DIV1 && div_done) begin
			x0_q <= rkb_pkg::sat32(rkb_pkg::sx64(pc_c) + rkb_pkg::sx64(rkb_pkg::sat32(div_quo)));
		end
		if (state_q == rkb_pkg::ST_BIAS_B) acc_q <= prod_q;
		if (state_q == rkb_pkg::ST_BIAS_IDX) idx_q <= rkb_pkg::sig_index(acc_q + prod_q);
		if (out_load) begin
			expand_goal_tree <= (pc_q[0] > pc_q[1]);
			chosen_bias <= (pc_q[0] > pc_q[1]) ? bias_q[1] : bias_q[0];
			start_bias <= bias_q[0];
			goal_bias <= bias_q[1];
			applied_increment <= action_q ? z_q : $signed({1'b0, mag_q});
		end
	end

	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted without leaving idle");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == rkb_pkg::ST_DIV1 || state_q == rkb_pkg::ST_DIV2))
		else $error("divider finished outside a divide step");

	a_bias_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rkb_pkg::ST_BIAS_WR) |=> (bias_q[sel_q] <= rkb_pkg::BIAS_MAX))
		else $error("bias above clamp after table write");

endmodule

// ----- hw/rtl/rkb_div.sv -----
// Radix-2 restoring signed divider, 64-bit dividend by 32-bit divisor, truncating.
module rkb_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [63:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [32:0] dmag_q;
	logic [63:0] shf_q;
	logic        neg_q;
	logic [33:0] trial;
	logic [33:0] shifted;

	assign shifted = {rem_q, shf_q[63]};
	assign trial = shifted - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= num[63] ? 64'(-num) : num;
			dmag_q <= den[31] ? 33'(-{den[31], den}) : {1'b0, den};
			rem_q <= '0;
			neg_q <= num[63] ^ den[31];
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				shf_q <= {shf_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[32:0];
				shf_q <= {shf_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -$signed(shf_q) : $signed(shf_q);

endmodule

// ----- bench/tb_reward_kalman_tree_bias.sv -----
// Self-checking bench for reward_kalman_tree_bias: directed, random and backpressure phases.
module tb_reward_kalman_tree_bias;

	localparam logic ACT_RESTART = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;
	localparam logic TREE_START = 1'b0;
	localparam logic TREE_GOAL = 1'b1;
	localparam int LUT_N = 256;
	localparam longint LIMIT_CYCLES = 3000000;
	localparam longint unsigned Q30 = 64'd1073741824;
	localparam longint unsigned EXP_WHOLE [9] = '{
		64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458457, 64'd19666267,
		64'd7234816, 64'd2661539, 64'd979126, 64'd360200
	};

	typedef struct {
		logic expand;
		logic [16:0] chosen;
		logic [16:0] sbias;
		logic [16:0] gbias;
		logic signed [31:0] applied;
	} bias_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall, action, filter_select, motion_valid;
	logic [30:0] reward_magnitude;
	logic out_valid, out_stall, expand_goal_tree;
	logic [16:0] chosen_bias, start_bias, goal_bias;
	logic signed [31:0] applied_increment;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;

	reward_kalman_tree_bias uut (.*);

	// filter state mirror
	logic [16:0] sig_lut [LUT_N];
	logic [16:0] cfg_nc, cfg_ni, cfg_wc, cfg_wi;
	logic [19:0] cfg_ps, cfg_ns;
	int est_cum [2], est_inc [2], p_cc [2], p_ci [2], p_ii [2];
	logic [16:0] bias_q [2];
	int clip_pos, clip_neg;

	bias_result_t pending_bias [$];
	int errors = 0;
	longint cycles = 0;
	bit tx_noisy = 1, rx_noisy = 1;
	int rx_hold = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_reward_kalman_tree_bias: errors");
			$finish;
		end
	end

	function automatic int sat_q(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint unsigned exp_neg(longint unsigned y);
		longint unsigned n, fr, acc, term;
		n = y >> 16;
		fr = (y & 64'hFFFF) << 14;
		acc = Q30;
		term = Q30;
		if (n > 8) n = 8;
		for (int k = 1; k <= 14; k++) begin
			term = ((term * fr) >> 30) / longint'(k);
			if (k % 2) acc = acc - term;
			else acc = acc + term;
		end
		return (EXP_WHOLE[n] * acc) >> 30;
	endfunction

	function automatic longint unsigned logistic_pos(longint unsigned y);
		longint unsigned d;
		d = Q30 + exp_neg(y);
		return ((64'd1 << 46) + d / 2) / d;
	endfunction

	function automatic void fill_lut();
		longint t;
		longint unsigned v;
		for (int i = 0; i < LUT_N; i++) begin
			t = ((2 * longint'(i) + 1) * 524288) / LUT_N - 524288;
			if (t >= 0) v = logistic_pos(t);
			else v = 65536 - logistic_pos(-t);
			sig_lut[i] = (v > 58982) ? 17'd58982 : v[16:0];
		end
	endfunction

	function automatic void kf_reset();
		cfg_nc = 66; cfg_ni = 7; cfg_wc = 45875; cfg_wi = 19661;
		cfg_ps = 65536; cfg_ns = 131072;
		for (int f = 0; f < 2; f++) begin
			est_cum[f] = 0; est_inc[f] = 0;
			p_cc[f] = 65536; p_ci[f] = 65536; p_ii[f] = 65536;
			bias_q[f] = 65536;
		end
		clip_pos = 0; clip_neg = 0;
	endfunction

	function automatic void kf_predict(int f, int x0, int x1, int a, int b, int c);
		est_cum[f] = sat_q(longint'(x0) + x1);
		est_inc[f] = x0;
		p_cc[f] = sat_q(longint'(a) + 2 * longint'(b) + c + longint'(cfg_nc));
		p_ci[f] = sat_q(longint'(a) + b);
		p_ii[f] = sat_q(longint'(a) + longint'(cfg_ni));
	endfunction

	function automatic void kf_bias(int f);
		longint s, span, idx;
		span = 64'sd34359738368;
		s = longint'(cfg_wc) * est_cum[f] + longint'(cfg_wi) * est_inc[f];
		if (s < -span) idx = 0;
		else if (s >= span) idx = LUT_N - 1;
		else idx = ((s + span) * LUT_N) >>> 36;
		bias_q[f] = sig_lut[idx];
	endfunction

	function automatic bias_result_t kf_step(logic act, logic sel, logic [30:0] mag, logic mv);
		bias_result_t r;
		longint m;
		int z, a, b, c, e, corr, x0, an;
		m = longint'(mag);
		if (act == ACT_RESTART) begin
			clip_pos = sat_q((longint'(cfg_ps) * m) >>> 16);
			clip_neg = sat_q((longint'(cfg_ns) * m) >>> 16);
			for (int f = 0; f < 2; f++) begin
				kf_predict(f, 0, int'(m), 65536, 65536, 65536);
				kf_bias(f);
			end
			z = int'(m);
		end else begin
			if (mv) z = (m >= clip_pos) ? clip_pos : int'(m);
			else z = (m >= clip_neg) ? -clip_neg : -int'(m);
			a = p_cc[sel]; b = p_ci[sel]; c = p_ii[sel];
			if (c == 0) kf_predict(sel, est_cum[sel], est_inc[sel], a, b, c);
			else begin
				e = sat_q(longint'(z) - est_inc[sel]);
				corr = sat_q((longint'(b) * e) / c);
				x0 = sat_q(longint'(est_cum[sel]) + corr);
				an = sat_q(longint'(a) - (longint'(b) * b) / c);
				kf_predict(sel, x0, z, an, 0, 0);
			end
			kf_bias(sel);
		end
		r.expand = est_cum[0] > est_cum[1];
		r.chosen = r.expand ? bias_q[1] : bias_q[0];
		r.sbias = bias_q[0];
		r.gbias = bias_q[1];
		r.applied = z;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		bias_result_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bias.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual applied %0d",
					$time, applied_increment);
				errors++;
			end else begin
				x = pending_bias.pop_front();
				if (expand_goal_tree !== x.expand) begin
					$display("%0t: expand_goal_tree expected %0d actual %0d",
						$time, x.expand, expand_goal_tree);
					errors++;
				end
				if (chosen_bias !== x.chosen) begin
					$display("%0t: chosen_bias expected %0d actual %0d",
						$time, x.chosen, chosen_bias);
					errors++;
				end
				if (start_bias !== x.sbias) begin
					$display("%0t: start_bias expected %0d actual %0d",
						$time, x.sbias, start_bias);
					errors++;
				end
				if (goal_bias !== x.gbias) begin
					$display("%0t: goal_bias expected %0d actual %0d",
						$time, x.gbias, goal_bias);
					errors++;
				end
				if (applied_increment !== x.applied) begin
					$display("%0t: applied_increment expected %0d actual %0d",
						$time, x.applied, applied_increment);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls plus long holds
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1;
				rx_hold--;
			end else
				out_stall <= rx_noisy && ($urandom_range(99) < 37);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(logic act, logic sel, logic [30:0] mag, logic mv);
		int gap;
		gap = 0;
		if (tx_noisy)
			while ($urandom_range(99) < 37) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		filter_select <= sel;
		reward_magnitude <= mag;
		motion_valid <= mv;
		#1;
		while (in_stall) begin
			@(negedge clk);
			#1;
		end
		pending_bias = {pending_bias, kf_step(act, sel, mag, mv)};
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (pending_bias.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			rkb_pkg::REG_NOISE_CUM: cfg_nc = val[16:0];
			rkb_pkg::REG_NOISE_INC: cfg_ni = val[16:0];
			rkb_pkg::REG_WEIGHT_CUM: cfg_wc = val[16:0];
			rkb_pkg::REG_WEIGHT_INC: cfg_wi = val[16:0];
			rkb_pkg::REG_POS_SIGMA: cfg_ps = val;
			rkb_pkg::REG_NEG_SIGMA: cfg_ns = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_all(logic [19:0] nc, ni, wc, wi, ps, ns);
		write_reg(rkb_pkg::REG_NOISE_CUM, nc);
		write_reg(rkb_pkg::REG_NOISE_INC, ni);
		write_reg(rkb_pkg::REG_WEIGHT_CUM, wc);
		write_reg(rkb_pkg::REG_WEIGHT_INC, wi);
		write_reg(rkb_pkg::REG_POS_SIGMA, ps);
		write_reg(rkb_pkg::REG_NEG_SIGMA, ns);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic [30:0] rand_mag();
		case ($urandom_range(3))
			0: return 31'($urandom);
			1: return 31'($urandom_range(262143));
			2: return 31'($urandom_range(16777215));
			default: return 31'h7FFFFFFF - 31'($urandom_range(255));
		endcase
	endfunction

	task automatic test_directed();
		// updates before any restart clip to zero
		send_req(ACT_UPDATE, TREE_START, 31'h7FFFFFFF, 1);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd1000, 0);
		send_req(ACT_RESTART, TREE_GOAL, 31'd0, 0);
		send_req(ACT_UPDATE, TREE_START, 31'd5, 1);
		send_req(ACT_RESTART, TREE_START, 31'h7FFFFFFF, 1);
		send_req(ACT_UPDATE, TREE_START, 31'h7FFFFFFF, 1);
		send_req(ACT_UPDATE, TREE_GOAL, 31'h7FFFFFFF, 0);
		send_req(ACT_RESTART, TREE_START, 31'd65536, 1);
		send_req(ACT_UPDATE, TREE_START, 31'd65536, 1);
		send_req(ACT_UPDATE, TREE_START, 31'd65535, 1);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd131072, 0);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd131071, 0);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd0, 0);
		send_req(ACT_UPDATE, TREE_START, 31'd0, 1);
		drain();
		// zero process noise drives increment variance to zero
		set_all(0, 0, 65536, 65536, 655360, 655360);
		send_req(ACT_RESTART, TREE_START, 31'd98304, 0);
		send_req(ACT_UPDATE, TREE_START, 31'd70000, 1);
		send_req(ACT_UPDATE, TREE_START, 31'd30000, 0);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd1, 1);
		send_req(ACT_UPDATE, TREE_GOAL, 31'd200000, 0);
		drain();
		set_all(65536, 65536, 0, 0, 0, 131072);
		send_req(ACT_RESTART, TREE_GOAL, 31'h55555555, 1);
		send_req(ACT_UPDATE, TREE_START, 31'h2AAAAAAA, 1);
		send_req(ACT_UPDATE, TREE_GOAL, 31'h2AAAAAAA, 0);
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			tx_noisy = (p != 2);
			rx_noisy = (p != 2);
			if (p == 0) set_all(66, 7, 45875, 19661, 65536, 131072);
			else if (p == 1) set_all(65536, 65536, 65536, 65536, 655360, 655360);
			else set_all(20'($urandom_range(65536)), 20'($urandom_range(65536)),
				20'($urandom_range(65536)), 20'($urandom_range(65536)),
				20'($urandom_range(655360)), 20'($urandom_range(655360, 131072)));
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(99) < 8 || i == 0)
					send_req(ACT_RESTART, 1'($urandom), rand_mag(), 1'($urandom));
				else
					send_req(ACT_UPDATE, 1'($urandom), rand_mag(), 1'($urandom));
			end
			drain();
		end
		tx_noisy = 1;
		rx_noisy = 1;
	endtask

	task automatic test_backpressure();
		rx_hold = 600;
		tx_noisy = 0;
		send_req(ACT_RESTART, TREE_START, 31'd131072, 1);
		for (int i = 0; i < 6; i++)
			send_req(ACT_UPDATE, 1'($urandom), rand_mag(), 1'($urandom));
		tx_noisy = 1;
		drain();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		action = 0;
		filter_select = 0;
		reward_magnitude = 0;
		motion_valid = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		fill_lut();
		kf_reset();
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(10, 150);
		test_backpressure();
		drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("tb_reward_kalman_tree_bias: clean");
		else
			$display("tb_reward_kalman_tree_bias: errors");
		$finish;
	end

endmodule
